// ===== rtl/core/ulatr_pkg.sv =====
package ulatr_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    LV_LOW  = 2'd0,
    LV_HIGH = 2'd1,
    LV_UNK  = 2'd2
  } lvl_e;

  localparam logic [1:0] CAS_LOW  = 2'd0;
  localparam logic [1:0] CAS_HIGH = 2'd2;

  localparam logic [3:0] REG_INT_STATUS = 4'd0;
  localparam logic [3:0] REG_INT_ENABLE = 4'd0;
  localparam logic [3:0] REG_START_LO   = 4'd2;
  localparam logic [3:0] REG_START_HI   = 4'd3;
  localparam logic [3:0] REG_RX_DATA    = 4'd4;
  localparam logic [3:0] REG_PAGE       = 4'd5;
  localparam logic [3:0] REG_DIVIDER    = 4'd6;
  localparam logic [3:0] REG_CONTROL    = 4'd7;

  localparam int unsigned IRQ_LINE_BIT  = 0;
  localparam int unsigned IRQ_POWER_BIT = 1;
  localparam int unsigned IRQ_DISP_BIT  = 2;
  localparam int unsigned IRQ_RTC_BIT   = 3;
  localparam int unsigned IRQ_RX_BIT    = 4;
  localparam int unsigned IRQ_TONE_BIT  = 6;
  localparam logic [7:0] IRQ_EVAL_MASK  = 8'h7C;
  localparam logic [7:0] INT_STATUS_RST = 8'h82;

  localparam logic [3:0] PAGE_ALIAS    = 4'd9;
  localparam logic [3:0] PAGE_KEYBOARD = 4'd8;

  localparam logic [2:0] COMM_TAPE_IN = 3'd0;
  localparam logic [2:0] COMM_SOUND   = 3'd1;
  localparam logic [2:0] COMM_RESET   = 3'd4;

  localparam logic [8:0] START_RST = 9'h0C0;

  localparam logic [1:0] RUN_MAX  = 2'd3;
  localparam logic [3:0] POS_STOP = 4'd9;
  localparam logic [3:0] POS_LAST_DATA = 4'd8;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] rom_data;
    logic [1:0] tape_level;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq;
    logic [3:0]  rom_page;
    logic [14:0] disp_start;
    logic [14:0] disp_base;
    logic [2:0]  disp_mode;
    logic [2:0]  comm_mode;
    logic        motor_on;
    logic        caps_lock;
    logic        sound_on;
    logic [7:0]  sound_divider;
  } result_t;

  typedef struct packed {
    logic       tick;
    logic       restart;
    logic [1:0] level;
  } tape_ctrl_t;

  typedef struct packed {
    logic tone_set;
    logic rx_set;
  } tape_evt_t;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic [3:0] bit_pos;
  } tape_stat_t;

  function automatic logic [14:0] base_for_mode(input logic [2:0] mode);
    logic [14:0] base;
    case (mode)
      3'd3:    base = 15'h4000;
      3'd4,
      3'd5,
      3'd7:    base = 15'h5800;
      3'd6:    base = 15'h6000;
      default: base = 15'h3000;
    endcase
    return base;
  endfunction

endpackage

// ===== rtl/core/ulatr_if.sv =====
interface ulatr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] reg_offset;
  logic [7:0] write_data;
  logic [7:0] rom_data;
  logic [1:0] tape_level;

  modport source (
    output valid, opcode, reg_offset, write_data, rom_data, tape_level,
    input  ready
  );
  modport sink (
    input  valid, opcode, reg_offset, write_data, rom_data, tape_level,
    output ready
  );
endinterface

interface ulatr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        irq;
  logic [3:0]  rom_page;
  logic [14:0] disp_start;
  logic [14:0] disp_base;
  logic [2:0]  disp_mode;
  logic [2:0]  comm_mode;
  logic        motor_on;
  logic        caps_lock;
  logic        sound_on;
  logic [7:0]  sound_divider;

  modport source (
    output valid, read_data, irq, rom_page, disp_start, disp_base, disp_mode,
           comm_mode, motor_on, caps_lock, sound_on, sound_divider,
    input  ready
  );
  modport sink (
    input  valid, read_data, irq, rom_page, disp_start, disp_base, disp_mode,
           comm_mode, motor_on, caps_lock, sound_on, sound_divider,
    output ready
  );
endinterface

// ===== rtl/core/ulatr_tape_rx.sv =====
module ulatr_tape_rx (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ulatr_pkg::tape_ctrl_t  ctrl_i,
  output ulatr_pkg::tape_evt_t   evt_o,
  output ulatr_pkg::tape_stat_t  stat_o
);

  ulatr_pkg::lvl_e hist_q [4];
  ulatr_pkg::lvl_e hist_d [4];
  logic [1:0] run_q, run_d;
  logic [3:0] pos_q, pos_d;
  logic [7:0] shift_q, shift_d;
  logic       start_q, start_d;
  logic       tone_q, tone_d;

  always_comb begin
    logic zero_pat;
    logic one_pat;
    hist_d   = hist_q;
    run_d    = run_q;
    pos_d    = pos_q;
    shift_d  = shift_q;
    start_d  = start_q;
    tone_d   = tone_q;
    evt_o    = '0;
    zero_pat = 1'b0;
    one_pat  = 1'b0;
    if (ctrl_i.restart) begin
      run_d  = '0;
      pos_d  = '0;
      tone_d = 1'b0;
      for (int i = 0; i < 4; i++) hist_d[i] = ulatr_pkg::LV_UNK;
    end else if (ctrl_i.tick) begin
      if (ctrl_i.level == ulatr_pkg::CAS_LOW || ctrl_i.level == ulatr_pkg::CAS_HIGH) begin
        hist_d[0] = hist_q[1];
        hist_d[1] = hist_q[2];
        hist_d[2] = hist_q[3];
        hist_d[3] = (ctrl_i.level == ulatr_pkg::CAS_HIGH) ? ulatr_pkg::LV_HIGH
                                                          : ulatr_pkg::LV_LOW;
        if (run_q != ulatr_pkg::RUN_MAX) run_d = run_q + 2'd1;
      end else begin
        run_d  = '0;
        pos_d  = '0;
        tone_d = 1'b0;
        for (int i = 0; i < 4; i++) hist_d[i] = ulatr_pkg::LV_UNK;
      end
      zero_pat = hist_d[0] == ulatr_pkg::LV_LOW  && hist_d[1] == ulatr_pkg::LV_LOW &&
                 hist_d[2] == ulatr_pkg::LV_HIGH && hist_d[3] == ulatr_pkg::LV_HIGH;
      one_pat  = hist_d[0] == ulatr_pkg::LV_LOW  && hist_d[1] == ulatr_pkg::LV_HIGH &&
                 hist_d[2] == ulatr_pkg::LV_LOW  && hist_d[3] == ulatr_pkg::LV_HIGH;
      if (run_d == ulatr_pkg::RUN_MAX && (zero_pat || one_pat)) begin
        run_d = '0;
        if (pos_q == '0) begin
          start_d = one_pat;
          if (!(one_pat && tone_q)) begin
            if (!one_pat) tone_d = 1'b0;
            pos_d = 4'd1;
          end
        end else if (pos_q <= ulatr_pkg::POS_LAST_DATA) begin
          shift_d = {one_pat, shift_q[7:1]};
          pos_d   = pos_q + 4'd1;
        end else begin
          if (pos_q == ulatr_pkg::POS_STOP) begin
            if (start_q && one_pat && shift_q == 8'hFF && !tone_q) begin
              evt_o.tone_set = 1'b1;
              tone_d         = 1'b1;
            end else if (!start_q && one_pat) begin
              evt_o.rx_set = 1'b1;
            end
          end
          pos_d = pos_q - ulatr_pkg::POS_STOP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) hist_q[i] <= ulatr_pkg::LV_UNK;
      run_q   <= '0;
      pos_q   <= '0;
      shift_q <= '0;
      start_q <= 1'b0;
      tone_q  <= 1'b0;
    end else begin
      hist_q  <= hist_d;
      run_q   <= run_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      start_q <= start_d;
      tone_q  <= tone_d;
    end
  end

  assign stat_o.shift_byte = shift_q;
  assign stat_o.bit_pos    = pos_q;

endmodule

// ===== rtl/core/ulatr_regs.sv =====
module ulatr_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  ulatr_pkg::item_t       item_i,
  input  ulatr_pkg::tape_evt_t   evt_i,
  input  ulatr_pkg::tape_stat_t  stat_i,
  output ulatr_pkg::tape_ctrl_t  ctrl_o,
  output ulatr_pkg::result_t     res_o
);

  logic [7:0] status_q, status_d;
  logic [7:0] enable_q, enable_d;
  logic [3:0] page_q, page_d;
  logic [8:0] start_q, start_d;
  logic [2:0] mode_q, mode_d;
  logic [2:0] comm_q, comm_d;
  logic       motor_q, motor_d;
  logic       caps_q, caps_d;
  logic [7:0] div_q, div_d;
  logic       active_q, active_d;

  always_comb begin
    logic       reeval;
    logic [7:0] rd;
    logic [7:0] wd;
    status_d = status_q;
    enable_d = enable_q;
    page_d   = page_q;
    start_d  = start_q;
    mode_d   = mode_q;
    comm_d   = comm_q;
    motor_d  = motor_q;
    caps_d   = caps_q;
    div_d    = div_q;
    active_d = active_q;
    reeval   = 1'b0;
    rd       = '0;
    wd       = item_i.write_data;
    ctrl_o.tick    = fire_i && item_i.opcode == ulatr_pkg::OP_TICK && active_q && motor_q;
    ctrl_o.restart = 1'b0;
    ctrl_o.level   = item_i.tape_level;
    if (fire_i) begin
      case (item_i.opcode)
        ulatr_pkg::OP_TICK: begin
          if (evt_i.tone_set) begin
            status_d[ulatr_pkg::IRQ_TONE_BIT] = 1'b1;
            reeval = 1'b1;
          end
          if (evt_i.rx_set) begin
            status_d[ulatr_pkg::IRQ_RX_BIT] = 1'b1;
            reeval = 1'b1;
          end
        end
        ulatr_pkg::OP_READ: begin
          unique case (item_i.reg_offset)
            ulatr_pkg::REG_INT_STATUS: begin
              rd = status_q;
              status_d[ulatr_pkg::IRQ_POWER_BIT] = 1'b0;
            end
            ulatr_pkg::REG_RX_DATA: begin
              rd = stat_i.shift_byte;
              status_d[ulatr_pkg::IRQ_RX_BIT] = 1'b0;
              reeval = 1'b1;
            end
            default: rd = item_i.rom_data;
          endcase
        end
        ulatr_pkg::OP_WRITE: begin
          unique case (item_i.reg_offset)
            ulatr_pkg::REG_INT_ENABLE: enable_d = wd;
            ulatr_pkg::REG_START_LO:   start_d  = {start_q[8:3], wd[7:5]};
            ulatr_pkg::REG_START_HI:   start_d  = {wd[5:0], start_q[2:0]};
            ulatr_pkg::REG_PAGE: begin
              if (page_q[3:2] != 2'b10 || wd[3]) begin
                page_d = (wd[3:0] == ulatr_pkg::PAGE_ALIAS) ? ulatr_pkg::PAGE_KEYBOARD
                                                             : wd[3:0];
              end
              if (wd[4]) status_d[ulatr_pkg::IRQ_DISP_BIT] = 1'b0;
              if (wd[5]) status_d[ulatr_pkg::IRQ_RTC_BIT]  = 1'b0;
              if (wd[6]) status_d[ulatr_pkg::IRQ_TONE_BIT] = 1'b0;
              reeval = |wd[6:4];
            end
            ulatr_pkg::REG_DIVIDER: begin
              if (comm_q == ulatr_pkg::COMM_SOUND) div_d = wd;
            end
            ulatr_pkg::REG_CONTROL: begin
              comm_d  = {1'b0, wd[2:1]};
              mode_d  = wd[5:3];
              motor_d = wd[6];
              caps_d  = wd[7];
              if ({1'b0, wd[2:1]} == ulatr_pkg::COMM_TAPE_IN) begin
                ctrl_o.restart = !active_q;
                active_d       = 1'b1;
              end else begin
                active_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (reeval) begin
        status_d[ulatr_pkg::IRQ_LINE_BIT] = |(status_d & enable_q & ulatr_pkg::IRQ_EVAL_MASK);
      end
    end
    res_o.read_data     = rd;
    res_o.irq           = status_d[ulatr_pkg::IRQ_LINE_BIT];
    res_o.rom_page      = page_d;
    res_o.disp_start    = {start_d, 6'b0};
    res_o.disp_base     = ulatr_pkg::base_for_mode(mode_d);
    res_o.disp_mode     = mode_d;
    res_o.comm_mode     = comm_d;
    res_o.motor_on      = motor_d;
    res_o.caps_lock     = caps_d;
    res_o.sound_on      = comm_d == ulatr_pkg::COMM_SOUND;
    res_o.sound_divider = div_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ulatr_pkg::INT_STATUS_RST;
      enable_q <= '0;
      page_q   <= '0;
      start_q  <= ulatr_pkg::START_RST;
      mode_q   <= '0;
      comm_q   <= ulatr_pkg::COMM_RESET;
      motor_q  <= 1'b0;
      caps_q   <= 1'b0;
      div_q    <= '0;
      active_q <= 1'b0;
    end else begin
      status_q <= status_d;
      enable_q <= enable_d;
      page_q   <= page_d;
      start_q  <= start_d;
      mode_q   <= mode_d;
      comm_q   <= comm_d;
      motor_q  <= motor_d;
      caps_q   <= caps_d;
      div_q    <= div_d;
      active_q <= active_d;
    end
  end

endmodule

// ===== rtl/core/ula_tape_receiver_and_irq_top.sv =====
// Cassette receiver and interrupt/register block of a home-computer I/O chip.
// Every item (tape tick, register read or register write) gives exactly one
// result item carrying the read byte, the interrupt line and the current
// paging, screen and control state. Items go through an input register, are
// processed combinationally against the block state and land in an output
// register, so one item is taken per clock while the output is not held, and
// each result is presented from the output register. Input ready follows output
// ready combinationally through both stages, so the block only stalls while
// the output is held.
module ula_tape_receiver_and_irq_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  ulatr_in_if.sink    in_i,
  ulatr_out_if.source out_o
);

  logic                   s1_valid_q;
  ulatr_pkg::item_t       s1_q;
  logic                   s1_fire;
  logic                   out_valid_q;
  ulatr_pkg::result_t     out_q;
  ulatr_pkg::result_t     res;
  ulatr_pkg::tape_ctrl_t  tape_ctrl;
  ulatr_pkg::tape_evt_t   tape_evt;
  ulatr_pkg::tape_stat_t  tape_stat;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (!out_valid_q || out_o.ready) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q.opcode     <= in_i.opcode;
      s1_q.reg_offset <= in_i.reg_offset;
      s1_q.write_data <= in_i.write_data;
      s1_q.rom_data   <= in_i.rom_data;
      s1_q.tape_level <= in_i.tape_level;
    end
    if (s1_fire) out_q <= res;
  end

  ulatr_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .item_i (s1_q),
    .evt_i  (tape_evt),
    .stat_i (tape_stat),
    .ctrl_o (tape_ctrl),
    .res_o  (res)
  );

  ulatr_tape_rx u_tape_rx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tape_ctrl),
    .evt_o  (tape_evt),
    .stat_o (tape_stat)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = out_q.read_data;
  assign out_o.irq           = out_q.irq;
  assign out_o.rom_page      = out_q.rom_page;
  assign out_o.disp_start    = out_q.disp_start;
  assign out_o.disp_base     = out_q.disp_base;
  assign out_o.disp_mode     = out_q.disp_mode;
  assign out_o.comm_mode     = out_q.comm_mode;
  assign out_o.motor_on      = out_q.motor_on;
  assign out_o.caps_lock     = out_q.caps_lock;
  assign out_o.sound_on      = out_q.sound_on;
  assign out_o.sound_divider = out_q.sound_divider;

  a_bit_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tape_stat.bit_pos < 4'd10)
    else $error("tape bit position out of range");

  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("processed item did not reach output register");

  a_page_alias: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.rom_page != ulatr_pkg::PAGE_ALIAS)
    else $error("rom page alias not folded");

endmodule
